// ----- sv/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
`default_nettype none
package rau_pkg;
   localparam int unsigned FIELD_BITS = 32;
   localparam int unsigned DEN_BITS   = 31;
   localparam int unsigned OP_BITS    = 2;

   localparam logic [OP_BITS-1:0] OP_ADD = 2'd0;
   localparam logic [OP_BITS-1:0] OP_SUB = 2'd1;
   localparam logic [OP_BITS-1:0] OP_MUL = 2'd2;

   typedef enum logic [15:0] {
      ST_IDLE   = 16'b0000_0000_0000_0001,
      ST_MUL0   = 16'b0000_0000_0000_0010,
      ST_MUL1   = 16'b0000_0000_0000_0100,
      ST_MUL2   = 16'b0000_0000_0000_1000,
      ST_COMB   = 16'b0000_0000_0001_0000,
      ST_FIX    = 16'b0000_0000_0010_0000,
      ST_GINIT  = 16'b0000_0000_0100_0000,
      ST_GSH    = 16'b0000_0000_1000_0000,
      ST_GX     = 16'b0000_0001_0000_0000,
      ST_GLOOP  = 16'b0000_0010_0000_0000,
      ST_SCALE  = 16'b0000_0100_0000_0000,
      ST_DINITN = 16'b0000_1000_0000_0000,
      ST_DIVN   = 16'b0001_0000_0000_0000,
      ST_DINITD = 16'b0010_0000_0000_0000,
      ST_DIVD   = 16'b0100_0000_0000_0000,
      ST_DONE   = 16'b1000_0000_0000_0000
   } state_type;

   typedef struct packed {
      logic load;
      logic mul0;
      logic mul1;
      logic mul2;
      logic comb;
      logic fix;
      logic ginit;
      logic gsh;
      logic gx;
      logic gloop;
      logic scale;
      logic dinit_n;
      logic div_step;
      logic dinit_d;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic rn_zero;
      logic both_even;
      logic x_even;
      logic y_zero;
      logic k_zero;
      logic div_last;
   } status_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] num;
      logic [DEN_BITS-1:0]   den;
      logic                  ovf;
   } result_type;
endpackage
`default_nettype wire

// ----- sv/rational_arith_unit.sv -----
// Top level of the rational arithmetic unit: ports, result register, checks.
//   channel | dir | beat contents
//   req_    | in  | operation, a_num, a_den, b_num, b_den
//   rsp_    | out | res_num, res_den; overflow in tuser
// One item at a time: setup makes three passes through one multiplier, then a
// binary GCD, then two restoring divisions by the divisor. A zero result skips
// GCD and division. The result register lets the next beat be taken while a
// result waits; the finish stalls until it is free.
// Synchronous reset clears control only.
`default_nettype none
module rational_arith_unit
   import rau_pkg::*;
#(
   parameter int unsigned WORD_BITS = 32
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire [135:0]  req_tdata,  // operation, a_num, a_den, b_num, b_den, zero pad
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [63:0]  rsp_tdata,  // res_num, res_den, zero pad
   output logic         rsp_tuser   // overflow
);
   cmd_type    cmd;
   status_type status;
   result_type result;
   logic       out_free;
   logic       rsp_valid_ff;
   result_type rsp_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   rau_dp #(.WORD_BITS(WORD_BITS)) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .operation (req_tdata[1:0]),
      .a_num     (req_tdata[33:2]),
      .a_den     (req_tdata[65:34]),
      .b_num     (req_tdata[97:66]),
      .b_den     (req_tdata[129:98]),
      .status    (status),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) rsp_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.den, rsp_ff.num};
   assign rsp_tuser  = rsp_ff.ovf;

`ifndef SYNTH
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("beat taken while busy");
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.ovf |-> rsp_ff.den != '0)
      else $error("zero denominator without overflow");
   a_zero_is_0_1: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.num == '0 && !rsp_ff.ovf |-> rsp_ff.den == DEN_BITS'(1))
      else $error("zero result not reduced to 0/1");
`endif
endmodule
`default_nettype wire

// ----- sv/rau_ctrl.sv -----
// Sequencer for the rational arithmetic unit.
`default_nettype none
module rau_ctrl
   import rau_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   input  wire        out_free,
   input  status_type status,
   output logic       req_ready,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MUL0;
         ST_MUL0:   state_in = ST_MUL1;
         ST_MUL1:   state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_COMB;
         ST_COMB:   state_in = ST_FIX;
         ST_FIX:    state_in = ST_GINIT;
         ST_GINIT:  state_in = status.rn_zero ? ST_DONE : ST_GSH;
         ST_GSH:    if (!status.both_even) state_in = ST_GX;
         ST_GX:     if (!status.x_even) state_in = ST_GLOOP;
         ST_GLOOP:  if (status.y_zero) state_in = ST_SCALE;
         ST_SCALE:  if (status.k_zero) state_in = ST_DINITN;
         ST_DINITN: state_in = ST_DIVN;
         ST_DIVN:   if (status.div_last) state_in = ST_DINITD;
         ST_DINITD: state_in = ST_DIVD;
         ST_DIVD:   if (status.div_last) state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.mul0     = (state_ff == ST_MUL0);
      cmd.mul1     = (state_ff == ST_MUL1);
      cmd.mul2     = (state_ff == ST_MUL2);
      cmd.comb     = (state_ff == ST_COMB);
      cmd.fix      = (state_ff == ST_FIX);
      cmd.ginit    = (state_ff == ST_GINIT);
      cmd.gsh      = (state_ff == ST_GSH) && status.both_even;
      cmd.gx       = (state_ff == ST_GX) && status.x_even;
      cmd.gloop    = (state_ff == ST_GLOOP) && !status.y_zero;
      cmd.scale    = (state_ff == ST_SCALE) && !status.k_zero;
      cmd.dinit_n  = (state_ff == ST_DINITN);
      cmd.div_step = (state_ff == ST_DIVN) || (state_ff == ST_DIVD);
      cmd.dinit_d  = (state_ff == ST_DINITD);
      cmd.finish   = (state_ff == ST_DONE) && out_free;
   end
endmodule
`default_nettype wire

// ----- sv/rau_dp.sv -----
// Datapath: shared multiplier, sign/magnitude combine, binary GCD, restoring divider.
`default_nettype none
module rau_dp
   import rau_pkg::*;
#(
   parameter int unsigned WORD_BITS = 32
) (
   input  wire                    clock,
   input  cmd_type                cmd,
   input  wire [OP_BITS-1:0]      operation,
   input  wire [FIELD_BITS-1:0]   a_num,
   input  wire [FIELD_BITS-1:0]   a_den,
   input  wire [FIELD_BITS-1:0]   b_num,
   input  wire [FIELD_BITS-1:0]   b_den,
   output status_type             status,
   output result_type             result
);
   localparam int unsigned W  = WORD_BITS;
   localparam int unsigned PW = 2 * WORD_BITS;
   localparam int unsigned KW = $clog2(PW);

   logic [OP_BITS-1:0] op_ff;
   logic               sa_ff, sb_ff, sr_ff, zero_ff;
   logic [W-1:0]       na_ff, da_ff, nb_ff, db_ff;
   logic [PW-1:0]      rd_ff, t1_ff, t2_ff, x_ff, y_ff, rem_ff, dvd_ff;
   logic [PW:0]        acc_ff;
   logic [KW-1:0]      k_ff, cnt_ff;

   logic          nna, dna, nnb, dnb;
   logic [W-1:0]  mna, mda, mnb, mdb, mda1, mdb1;
   logic [W-1:0]  mul_a, mul_b;
   logic [PW-1:0] prod;
   logic          sbe, same;
   logic [PW:0]   sum, diff;
   logic [PW:0]   div_tr, div_sub;
   logic [PW-1:0] rn_mag, rn_neg;

   always_comb begin
      nna  = a_num[W-1];
      dna  = a_den[W-1];
      nnb  = b_num[W-1];
      dnb  = b_den[W-1];
      mna  = nna ? (W)'(-a_num[W-1:0]) : a_num[W-1:0];
      mda  = dna ? (W)'(-a_den[W-1:0]) : a_den[W-1:0];
      mnb  = nnb ? (W)'(-b_num[W-1:0]) : b_num[W-1:0];
      mdb  = dnb ? (W)'(-b_den[W-1:0]) : b_den[W-1:0];
      mda1 = (mda == '0) ? (W)'(1) : mda;
      mdb1 = (mdb == '0) ? (W)'(1) : mdb;
   end

   always_comb begin
      mul_a = da_ff;
      mul_b = db_ff;
      if (cmd.mul1) begin
         mul_a = na_ff;
         mul_b = op_ff[1] ? nb_ff : db_ff;
      end else if (cmd.mul2) begin
         mul_a = da_ff;
         mul_b = nb_ff;
      end
      prod = PW'(mul_a) * PW'(mul_b);
   end

   always_comb begin
      sbe     = sb_ff ^ (op_ff == OP_SUB);
      same    = (sa_ff == sbe);
      sum     = {1'b0, t1_ff} + {1'b0, t2_ff};
      diff    = {1'b0, t1_ff} - {1'b0, t2_ff};
      div_tr  = {rem_ff, dvd_ff[PW-1]};
      div_sub = div_tr - {1'b0, x_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= operation;
         na_ff <= mna;
         nb_ff <= mnb;
         da_ff <= mda1;
         db_ff <= mdb1;
         sa_ff <= (nna != (dna && (mda != '0))) && (mna != '0);
         sb_ff <= (nnb != (dnb && (mdb != '0))) && (mnb != '0);
      end
      if (cmd.mul0) rd_ff <= prod;
      if (cmd.mul1) t1_ff <= prod;
      if (cmd.mul2) t2_ff <= prod;
      if (cmd.comb) begin
         if (op_ff[1]) begin
            acc_ff <= {1'b0, t1_ff};
            sr_ff  <= sa_ff ^ sb_ff;
         end else if (same) begin
            acc_ff <= sum;
            sr_ff  <= sa_ff;
         end else begin
            acc_ff <= diff;
            sr_ff  <= diff[PW] ? sbe : sa_ff;
         end
      end
      if (cmd.fix && acc_ff[PW]) acc_ff <= (PW+1)'(-acc_ff);
      if (cmd.ginit) begin
         x_ff    <= acc_ff[PW-1:0];
         y_ff    <= rd_ff;
         k_ff    <= '0;
         zero_ff <= (acc_ff == '0);
      end
      if (cmd.gsh) begin
         x_ff <= x_ff >> 1;
         y_ff <= y_ff >> 1;
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.gx) x_ff <= x_ff >> 1;
      if (cmd.gloop) begin
         if (!y_ff[0]) begin
            y_ff <= y_ff >> 1;
         end else if (x_ff > y_ff) begin
            x_ff <= y_ff;
            y_ff <= x_ff - y_ff;
         end else begin
            y_ff <= y_ff - x_ff;
         end
      end
      if (cmd.scale) begin
         x_ff <= x_ff << 1;
         k_ff <= k_ff - 1'b1;
      end
      if (cmd.dinit_n) begin
         rem_ff <= '0;
         dvd_ff <= acc_ff[PW-1:0];
         cnt_ff <= '0;
      end
      if (cmd.dinit_d) begin
         acc_ff <= {1'b0, dvd_ff};
         rem_ff <= '0;
         dvd_ff <= rd_ff;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (!div_sub[PW]) begin
            rem_ff <= div_sub[PW-1:0];
            dvd_ff <= {dvd_ff[PW-2:0], 1'b1};
         end else begin
            rem_ff <= div_tr[PW-1:0];
            dvd_ff <= {dvd_ff[PW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      status.rn_zero   = (acc_ff == '0);
      status.both_even = !x_ff[0] && !y_ff[0];
      status.x_even    = !x_ff[0];
      status.y_zero    = (y_ff == '0);
      status.k_zero    = (k_ff == '0);
      status.div_last  = (cnt_ff == KW'(PW-1));
   end

   always_comb begin
      rn_mag     = acc_ff[PW-1:0];
      rn_neg     = PW'(-rn_mag);
      result     = '0;
      if (zero_ff) begin
         result.den[0] = 1'b1;
      end else begin
         result.num[W-1:0] = sr_ff ? rn_neg[W-1:0] : rn_mag[W-1:0];
         result.den[W-2:0] = dvd_ff[W-2:0];
         result.ovf = (dvd_ff[PW-1:W-1] != '0)
                    || (sr_ff ? ((rn_mag[PW-1:W] != '0)
                                 || (rn_mag[W-1] && (rn_mag[W-2:0] != '0)))
                              : (rn_mag[PW-1:W-1] != '0));
      end
   end
endmodule
`default_nettype wire

// ----- test/rational_arith_unit_tb.sv -----
// Testbench for rational_arith_unit: directed table, then random fractions checked by a predictor.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_unit_tb;
   import rau_pkg::*;

   typedef struct {
      logic [OP_BITS-1:0]    op;
      logic [FIELD_BITS-1:0] an;
      logic [FIELD_BITS-1:0] ad;
      logic [FIELD_BITS-1:0] bn;
      logic [FIELD_BITS-1:0] bd;
      bit                    typed;
      result_type            res;
   } vec_type;

   localparam longint unsigned TIMEOUT = 4_000_000;
   localparam logic [FIELD_BITS-1:0] MIN32 = 32'h8000_0000;
   localparam logic [FIELD_BITS-1:0] MAX32 = 32'h7fff_ffff;
   localparam logic [FIELD_BITS-1:0] NEG1  = 32'hffff_ffff;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [135:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [63:0] rsp_tdata;
   logic rsp_tuser;

   result_type expected_q[$];
   int errors, beats_in, beats_out, ovf_seen;
   int send_idle, recv_idle;
   longint unsigned cycles = 0;

   rational_arith_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void split(input logic [31:0] v, output bit neg,
                                 output logic [63:0] mag);
      neg = v[31];
      mag = neg ? {32'd0, -v} : {32'd0, v};
   endfunction

   function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic result_type reduce_fraction(input vec_type v);
      result_type r;
      bit nan, dan, nbn, dbn, sa, sb, sr;
      logic [63:0] na, da, nb, db, rn, rd, t1, t2, g;
      split(v.an, nan, na);
      split(v.ad, dan, da);
      split(v.bn, nbn, nb);
      split(v.bd, dbn, db);
      if (da == 0) begin da = 1; dan = 0; end
      if (db == 0) begin db = 1; dbn = 0; end
      sa = (nan != dan) && na != 0;
      sb = (nbn != dbn) && nb != 0;
      rd = da * db;
      if (v.op[1]) begin
         rn = na * nb;
         sr = sa != sb;
      end else begin
         t1 = na * db;
         t2 = da * nb;
         if (v.op == OP_SUB) sb = !sb;
         if (sa == sb) begin rn = t1 + t2; sr = sa; end
         else if (t1 >= t2) begin rn = t1 - t2; sr = sa; end
         else begin rn = t2 - t1; sr = sb; end
      end
      if (rn == 0) begin
         r.num = '0; r.den = 31'd1; r.ovf = 1'b0;
         return r;
      end
      g = gcd64(rn, rd);
      rn = rn / g;
      rd = rd / g;
      r.ovf = (rd > 64'h7fff_ffff) || (sr ? rn > 64'h8000_0000 : rn > 64'h7fff_ffff);
      t1 = sr ? -rn : rn;
      r.num = t1[31:0];
      r.den = rd[30:0];
      return r;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      $display("mismatch beat %0d %s: got %h expected %h", beats_out, what, got, want);
   endtask

   function automatic vec_type row(input logic [1:0] op, input logic [31:0] an, ad, bn, bd,
                                   input bit typed = 0, input logic [31:0] rn = 0,
                                   input logic [30:0] rd = 1, input bit ov = 0);
      vec_type v;
      v.op = op; v.an = an; v.ad = ad; v.bn = bn; v.bd = bd;
      v.typed = typed; v.res.num = rn; v.res.den = rd; v.res.ovf = ov;
      return v;
   endfunction

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 9))
         0: return MIN32;
         1: return MAX32;
         2: return 32'(int'($urandom_range(0, 20)) - 10);
         3, 4: return 32'(int'($urandom_range(0, 2000)) - 1000);
         5: return $urandom_range(0, 1) ? 32'd0 : NEG1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send(input vec_type v);
      req_tdata <= {6'b0, v.bd, v.bn, v.ad, v.an, v.op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      beats_in++;
      expected_q.push_back(v.typed ? v.res : reduce_fraction(v));
      if ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
         if (rsp_tvalid && rsp_tready) begin
            beats_out++;
            if (expected_q.size() == 0) begin
               report("unexpected beat", rsp_tdata, 0);
            end else begin
               automatic result_type e = expected_q.pop_front();
               if (rsp_tdata[31:0] !== e.num) report("res_num", rsp_tdata[31:0], e.num);
               if (rsp_tdata[62:32] !== e.den) report("res_den", rsp_tdata[62:32], e.den);
               if (rsp_tuser !== e.ovf) report("overflow", rsp_tuser, e.ovf);
               if (rsp_tuser) ovf_seen++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > TIMEOUT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      vec_type dir[$];
      vec_type v;
      int phase;
      errors = 0; beats_in = 0; beats_out = 0; ovf_seen = 0;
      send_idle = 0; recv_idle = 0;
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      dir.push_back(row(OP_ADD, 32'd0, 32'd0, 32'd0, 32'd0, 1, 32'd0, 31'd1, 0));
      dir.push_back(row(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 1, 32'd5, 31'd6, 0));
      dir.push_back(row(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2, 1, 32'd0, 31'd1, 0));
      dir.push_back(row(OP_MUL, 32'd2, 32'd3, 32'd3, 32'd4, 1, 32'd1, 31'd2, 0));
      dir.push_back(row(2'd3, 32'd2, 32'd3, 32'd3, 32'd4, 1, 32'd1, 31'd2, 0));
      dir.push_back(row(OP_ADD, 32'd5, 32'd0, 32'd0, 32'd7, 1, 32'd5, 31'd1, 0));
      dir.push_back(row(OP_ADD, 32'd3, NEG1, 32'd0, 32'd1, 1, -32'sd3, 31'd1, 0));
      dir.push_back(row(OP_MUL, MIN32, 32'd1, 32'd1, 32'd1, 1, MIN32, 31'd1, 0));
      dir.push_back(row(OP_MUL, MIN32, NEG1, 32'd1, 32'd1, 1, MIN32, 31'd1, 1));
      dir.push_back(row(OP_ADD, MAX32, 32'd1, MAX32, 32'd1, 1, 32'hffff_fffe, 31'd1, 1));
      dir.push_back(row(OP_MUL, 32'd1, MAX32, 32'd1, MAX32));
      dir.push_back(row(OP_SUB, MIN32, MAX32, MAX32, MIN32));
      dir.push_back(row(OP_ADD, MIN32, MIN32, MIN32, MIN32));
      dir.push_back(row(OP_SUB, NEG1, NEG1, MIN32, MAX32));
      dir.push_back(row(OP_MUL, MIN32, MIN32, MAX32, MAX32));
      dir.push_back(row(OP_ADD, 32'd0, MIN32, 32'd0, NEG1));
      dir.push_back(row(OP_SUB, 32'd6, 32'd4, 32'hffff_fffa, 32'hffff_fffc));
      dir.push_back(row(OP_ADD, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555));

      send_idle = 22; recv_idle = 51;
      foreach (dir[i]) send(dir[i]);
      for (int n = 0; n < 1900; n++) begin
         phase = n / 634;
         send_idle = (phase == 0) ? 22 : (phase == 1) ? 51 : 0;
         recv_idle = (phase == 0) ? 51 : (phase == 1) ? 22 : 0;
         v = row(2'($urandom_range(0, 3)), rand_field(), rand_field(), rand_field(),
                 rand_field());
         send(v);
      end
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (800) @(posedge clock);

      $display("sent %0d beats, checked %0d results, %0d with overflow",
               beats_in, beats_out, ovf_seen);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
sv/rau_pkg.sv
sv/rau_ctrl.sv
sv/rau_dp.sv
sv/rational_arith_unit.sv
test/rational_arith_unit_tb.sv
